// ===== rtl/mcpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor command packet framer package
// Shared types and constants: queue entry, configuration bundle, register
// indexes and packet byte positions.
// ----------------------------------------------------------------------------
package mcpf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_HEADER   = 3'd0;
  localparam logic [2:0] CFG_FOOTER   = 3'd1;
  localparam logic [2:0] CFG_CMD_TYPE = 3'd2;
  localparam logic [2:0] CFG_DATA_LEN = 3'd3;
  localparam logic [2:0] CFG_MODE     = 3'd4;

  // Byte positions inside the per-motor emission sequence.
  localparam logic [4:0] IDX_HEADER     = 5'd0;
  localparam logic [4:0] IDX_CMD        = 5'd1;
  localparam logic [4:0] IDX_LEN_HI     = 5'd2;
  localparam logic [4:0] IDX_LEN_LO     = 5'd3;
  localparam logic [4:0] IDX_SEQ        = 5'd4;
  localparam logic [4:0] IDX_HDR_RSVD   = 5'd5;
  localparam logic [4:0] IDX_WORD_FIRST = 5'd6;
  localparam logic [4:0] IDX_WORD_LAST  = 5'd13;
  localparam logic [4:0] IDX_CKSUM      = 5'd22;
  localparam logic [4:0] IDX_FOOTER     = 5'd23;

  // Queue between the converter pipeline and the byte sequencer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [11:0] kp;
    logic [8:0]  kd;
    logic [15:0] pos;
    logic [11:0] vel;
    logic [11:0] tq;
    logic [7:0]  seq;
    logic        first;
    logic        last;
  } mcpf_item_t;

  typedef struct packed {
    logic [7:0]  header;
    logic [7:0]  footer;
    logic [7:0]  cmd_byte;
    logic [15:0] data_len;
    logic [2:0]  mode;
  } mcpf_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/motor_command_packet_framer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor command packet framer
// Converts Q16 motor commands into packed 64-bit words and frames them into
// a byte stream with header, reserved bytes, XOR checksum and footer.
// ----------------------------------------------------------------------------
// Each accepted motor command leaves as 8 bytes, 14 for the first motor of a
// packet (6 header bytes first) and 18 for the last one (8 reserved zero
// bytes, the checksum and the footer follow); a packet of N motors is
// 8*N + 16 bytes. The output lane carries one byte per cycle while out_stall
// is low, and the byte stream runs without gaps as long as items keep
// arriving. Conversion registers the products and then the codes between
// acceptance and the queue; a four-entry queue lets new commands be accepted
// while bytes of earlier ones are still being sent. Configuration writes are
// taken whenever reset is released.
module motor_command_packet_framer_unit #(
  parameter int MOTORS_PER_PACKET = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [19:0]        in_kp_gain,
  input  wire logic [21:0]        in_kd_gain,
  input  wire logic signed [23:0] in_target_position,
  input  wire logic signed [23:0] in_target_velocity,
  input  wire logic signed [23:0] in_feedforward_torque,
  input  wire logic [7:0]         in_sequence_number,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_packet_end,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  mcpf_pkg::mcpf_cfg_t                cfg_r;
  mcpf_pkg::mcpf_item_t               push_item;
  mcpf_pkg::mcpf_item_t               pop_item;
  logic                               push;
  logic                               pop;
  logic                               q_not_empty;
  logic [mcpf_pkg::QCNT_W-1:0]        q_level;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mcpf_pkg::CFG_HEADER:   cfg_r.header   <= cfg_data[7:0];
        mcpf_pkg::CFG_FOOTER:   cfg_r.footer   <= cfg_data[7:0];
        mcpf_pkg::CFG_CMD_TYPE: cfg_r.cmd_byte <= cfg_data[7:0];
        mcpf_pkg::CFG_DATA_LEN: cfg_r.data_len <= cfg_data;
        mcpf_pkg::CFG_MODE:     cfg_r.mode     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  mcpf_front #(
    .MOTORS_PER_PACKET (MOTORS_PER_PACKET)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .kp_gain            (in_kp_gain),
    .kd_gain            (in_kd_gain),
    .target_position    (in_target_position),
    .target_velocity    (in_target_velocity),
    .feedforward_torque (in_feedforward_torque),
    .sequence_number    (in_sequence_number),
    .q_level            (q_level),
    .q_push             (push),
    .q_item             (push_item)
  );

  mcpf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_item   (push_item),
    .pop       (pop),
    .rd_item   (pop_item),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  mcpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_item         (pop_item),
    .q_not_empty    (q_not_empty),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end)
  );

endmodule
`default_nettype wire

// ===== rtl/mcpf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor command front end
// Accepts motor commands, converts each value to its saturated raw code in a
// two-stage pipeline, tags the first and last motor of a packet and pushes
// the result into the queue.
// ----------------------------------------------------------------------------
module mcpf_front #(
  parameter int MOTORS_PER_PACKET = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [19:0]                   kp_gain,
  input  wire logic [21:0]                   kd_gain,
  input  wire logic signed [23:0]            target_position,
  input  wire logic signed [23:0]            target_velocity,
  input  wire logic signed [23:0]            feedforward_torque,
  input  wire logic [7:0]                    sequence_number,
  input  wire logic [mcpf_pkg::QCNT_W-1:0]   q_level,
  output logic                               q_push,
  output mcpf_pkg::mcpf_item_t               q_item
);

  localparam int CntW = (MOTORS_PER_PACKET > 1) ? $clog2(MOTORS_PER_PACKET) : 1;
  localparam logic [CntW-1:0] LastMotor = CntW'(MOTORS_PER_PACKET - 1);

  localparam logic [29:0]        KpMul     = 30'd819;
  localparam logic [35:0]        KdMul     = 36'd10000;
  localparam logic [35:0]        KdRound   = 36'd32047104;  // 978 * 2^15
  localparam logic [38:0]        KdRecip   = 39'd548948;    // ceil(2^28 / 489)
  localparam logic [19:0]        KdDiv     = 20'd489;
  localparam logic signed [24:0] PosOffset = 25'sd3932160;  // 60 * 2^16
  localparam logic signed [38:0] PosMul    = 39'sd4369;
  localparam logic signed [34:0] VelMul    = 35'sd273;
  localparam int                 QCNT_W_P1 = mcpf_pkg::QCNT_W + 1;

  // Offset conversion: round half up by 2^19, negative sums give code 0.
  function automatic logic [15:0] offset_code(input logic signed [39:0] prod,
                                              input logic [15:0] maxv);
    logic signed [39:0] num;
    logic [20:0]        q;
    num = prod + 40'sd262144;
    q   = num[39:19];
    if (num[39]) begin
      return 16'd0;
    end else if (q > 21'(maxv)) begin
      return maxv;
    end else begin
      return q[15:0];
    end
  endfunction

  logic [CntW-1:0] motor_cnt_r;
  logic            accept;
  logic            is_first;
  logic            is_last;
  logic [QCNT_W_P1-1:0] occupancy;

  logic signed [24:0] pos_sum;
  logic signed [24:0] vel_sum;
  logic signed [24:0] tq_sum;

  // Stage one: products.
  logic                v1_r;
  logic [29:0]         kp_prod_r;
  logic [35:0]         kd_prod_r;
  logic signed [38:0]  pos_prod_r;
  logic signed [34:0]  vel_prod_r;
  logic signed [34:0]  tq_prod_r;
  logic [7:0]          seq1_r;
  logic                first1_r;
  logic                last1_r;

  // Stage two: codes, damping quotient estimate.
  logic                v2_r;
  logic [11:0]         kp_code_r;
  logic [15:0]         pos_code_r;
  logic [11:0]         vel_code_r;
  logic [11:0]         tq_code_r;
  logic [18:0]         kd_t_r;
  logic [38:0]         kd_mul_r;
  logic [7:0]          seq2_r;
  logic                first2_r;
  logic                last2_r;

  logic [29:0]         kp_sum;
  logic [13:0]         kp_q;
  logic [35:0]         kd_sum;
  logic [18:0]         kd_t;
  logic [10:0]         kd_est;
  logic [19:0]         kd_back;
  logic [19:0]         kd_rem;
  logic [10:0]         kd_q;

  // The pipeline never stalls: an item is taken only if the queue has room
  // for it and for everything already in flight.
  assign occupancy = QCNT_W_P1'(q_level) + QCNT_W_P1'(v1_r) + QCNT_W_P1'(v2_r);
  assign in_stall  = !rst_n || (occupancy >= QCNT_W_P1'(mcpf_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign is_first  = (motor_cnt_r == '0);
  assign is_last   = (motor_cnt_r == LastMotor);

  assign pos_sum = 25'(target_position) + PosOffset;
  assign vel_sum = 25'(target_velocity) + PosOffset;
  assign tq_sum  = 25'(feedforward_torque) + PosOffset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_cnt_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      if (accept) begin
        motor_cnt_r <= is_last ? '0 : motor_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kp_prod_r  <= 30'(kp_gain) * KpMul;
      kd_prod_r  <= 36'(kd_gain) * KdMul;
      pos_prod_r <= 39'(pos_sum) * PosMul;
      vel_prod_r <= 35'(vel_sum) * VelMul;
      tq_prod_r  <= 35'(tq_sum) * VelMul;
      seq1_r     <= sequence_number;
      first1_r   <= is_first;
      last1_r    <= is_last;
    end
  end

  assign kp_sum = kp_prod_r + 30'd32768;
  assign kp_q   = kp_sum[29:16];
  // Damping divides by 978 * 2^16 = 489 * 2^17: shift first, then by 489.
  assign kd_sum = kd_prod_r + KdRound;
  assign kd_t   = kd_sum[35:17];

  always_ff @(posedge clk) begin
    if (v1_r) begin
      kp_code_r  <= (kp_q > 14'd4095) ? 12'd4095 : kp_q[11:0];
      pos_code_r <= offset_code(40'(pos_prod_r), 16'd65535);
      vel_code_r <= 12'(offset_code(40'(vel_prod_r), 16'd4095));
      tq_code_r  <= 12'(offset_code(40'(tq_prod_r), 16'd4095));
      kd_t_r     <= kd_t;
      kd_mul_r   <= 39'(kd_t) * KdRecip;
      seq2_r     <= seq1_r;
      first2_r   <= first1_r;
      last2_r    <= last1_r;
    end
  end

  // The reciprocal estimate is low by at most one; one compare fixes it.
  assign kd_est  = kd_mul_r[38:28];
  assign kd_back = 20'(kd_est) * KdDiv;
  assign kd_rem  = 20'(kd_t_r) - kd_back;
  assign kd_q    = (kd_rem >= KdDiv) ? kd_est + 11'd1 : kd_est;

  assign q_push = v2_r;

  always_comb begin
    q_item       = '0;
    q_item.kp    = kp_code_r;
    q_item.kd    = (kd_q > 11'd511) ? 9'd511 : kd_q[8:0];
    q_item.pos   = pos_code_r;
    q_item.vel   = vel_code_r;
    q_item.tq    = tq_code_r;
    q_item.seq   = seq2_r;
    q_item.first = first2_r;
    q_item.last  = last2_r;
  end

endmodule
`default_nettype wire

// ===== rtl/mcpf_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor word queue
// Short first-in first-out queue of converted motor items between the front
// end and the byte sequencer.
// ----------------------------------------------------------------------------
module mcpf_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire mcpf_pkg::mcpf_item_t          wr_item,
  input  wire logic                          pop,
  output mcpf_pkg::mcpf_item_t               rd_item,
  output logic                               not_empty,
  output logic [mcpf_pkg::QCNT_W-1:0]        level
);

  mcpf_pkg::mcpf_item_t              mem_r [mcpf_pkg::QUEUE_DEPTH];
  logic [mcpf_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [mcpf_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [mcpf_pkg::QCNT_W-1:0]       count_r;
  logic                              do_pop;

  assign not_empty = (count_r != '0);
  assign level     = count_r;
  assign rd_item   = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mcpf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packet byte sequencer
// Takes converted motor items from the queue and emits the packet one byte
// per cycle while out_stall is low: header for the first motor, the eight
// word bytes, and for the last motor the reserved bytes, checksum and footer.
// ----------------------------------------------------------------------------
module mcpf_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mcpf_pkg::mcpf_cfg_t   cfg,
  input  wire mcpf_pkg::mcpf_item_t  q_item,
  input  wire logic                  q_not_empty,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_packet_end
);

  mcpf_pkg::mcpf_item_t cur_r;
  logic                 busy_r;
  logic [4:0]           idx_r;
  logic [7:0]           cksum_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_end_r;

  logic                 out_can;
  logic                 emit;
  logic                 at_end;
  logic                 load;
  logic [4:0]           end_idx;
  logic [63:0]          word;
  logic [2:0]           word_sel;
  logic [2:0]           word_rev;
  logic [7:0]           byte_val;

  assign out_can  = !out_valid_r || !out_stall;
  assign emit     = busy_r && out_can;
  assign end_idx  = cur_r.last ? mcpf_pkg::IDX_FOOTER : mcpf_pkg::IDX_WORD_LAST;
  assign at_end   = (idx_r == end_idx);
  assign load     = q_not_empty && (!busy_r || (emit && at_end));
  assign q_pop    = load;

  assign word     = {cfg.mode, cur_r.kp, cur_r.kd, cur_r.pos, cur_r.vel, cur_r.tq};
  assign word_sel = 3'(idx_r - mcpf_pkg::IDX_WORD_FIRST);
  assign word_rev = 3'd7 - word_sel;

  always_comb begin
    byte_val = 8'd0;
    if (idx_r >= mcpf_pkg::IDX_WORD_FIRST && idx_r <= mcpf_pkg::IDX_WORD_LAST) begin
      byte_val = word[{word_rev, 3'b000} +: 8];
    end else begin
      case (idx_r)
        mcpf_pkg::IDX_HEADER:   byte_val = cfg.header;
        mcpf_pkg::IDX_CMD:      byte_val = cfg.cmd_byte;
        mcpf_pkg::IDX_LEN_HI:   byte_val = cfg.data_len[15:8];
        mcpf_pkg::IDX_LEN_LO:   byte_val = cfg.data_len[7:0];
        mcpf_pkg::IDX_SEQ:      byte_val = cur_r.seq;
        mcpf_pkg::IDX_HDR_RSVD: byte_val = 8'd0;
        mcpf_pkg::IDX_CKSUM:    byte_val = cksum_r;
        mcpf_pkg::IDX_FOOTER:   byte_val = cfg.footer;
        default:                byte_val = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cksum_r     <= 8'd0;
    end else begin
      if (out_can) begin
        out_valid_r <= emit;
      end
      if (emit) begin
        // The checksum restarts with the header byte of each packet.
        cksum_r <= (idx_r == mcpf_pkg::IDX_HEADER) ? byte_val : cksum_r ^ byte_val;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && at_end) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_val;
      out_end_r  <= (idx_r == mcpf_pkg::IDX_FOOTER);
    end
    if (load) begin
      cur_r <= q_item;
      idx_r <= q_item.first ? mcpf_pkg::IDX_HEADER : mcpf_pkg::IDX_WORD_FIRST;
    end else if (emit && !at_end) begin
      idx_r <= idx_r + 5'd1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_packet_end = out_end_r;

endmodule
`default_nettype wire

// ===== rtl/mcpf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor command packet framer checker
// Port-level assertions on the framer's output stream, bound to the top
// level.
// ----------------------------------------------------------------------------
module mcpf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_packet_end
);

  logic seen_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_in_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      seen_in_r <= 1'b1;
    end
  end

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled output transaction holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_packet_end))
    else $error("stalled output changed");

  // An accepted footer is not directly followed by another packet end.
  a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_packet_end |=> !(out_valid && out_packet_end))
    else $error("two packet ends in a row");

  // No output byte appears before any command transaction was taken.
  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_in_r)
    else $error("output without input");

endmodule

bind motor_command_packet_framer_unit mcpf_checker u_mcpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_packet_end (out_packet_end)
);
`default_nettype wire
